### rtl/assert_macros.svh
// assertion macros used by drrip_ctrl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication checked outside reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### rtl/drrip_pkg.sv
// shared types and constants for the drrip dead block replacement block
// no dependencies
`timescale 1ns / 1ps
package drrip_pkg;
	localparam int SETS = 2048;
	localparam int WAYS = 16;
	localparam int LEADER_SETS = 64;
	localparam int SELECTOR_BITS = 10;
	localparam int SET_W = $clog2(SETS);
	localparam int WAY_W = $clog2(WAYS);
	localparam int ROW_W = 4 * WAYS;
	localparam int CNT_W = 20;
	localparam logic [1:0] RV_MAX = 2'd3;
	localparam logic [1:0] DEAD_MAX = 2'd3;
	localparam logic ACT_VICTIM = 1'b0;
	localparam logic ACT_UPDATE = 1'b1;

	// command from controller to datapath
	typedef struct packed {
		logic read;       // issue row read for captured request
		logic write;      // write back computed row, maybe emit result
		logic clr;        // write reset row at sweep address
		logic decay_rd;   // read row at sweep address for decay
		logic decay_wr;   // write decayed row at sweep address
		logic load;       // capture input beat
	} dp_cmd_t;

	typedef struct packed {
		logic sweep_last; // sweep address at final set
		logic decay_due;  // update being written triggers a decay
		logic is_victim;  // captured request is a victim request
	} dp_stat_t;
endpackage

### rtl/drrip_ctrl.sv
// controller state machine: clear sweep, request sequencing, decay sweep
// depends on drrip_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module drrip_ctrl import drrip_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     out_busy,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);
	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_READ  = 6'b000100,
		ST_WRITE = 6'b001000,
		ST_DRD   = 6'b010000,
		ST_DWR   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (stat.sweep_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = !out_busy;
				if (in_valid && !out_busy) begin
					cmd.load = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				cmd.write = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		if (state_q == ST_WRITE && stat.decay_due && !stat.is_victim) state_d = ST_DRD;
		if (state_q == ST_DRD) begin
			cmd.decay_rd = 1'b1;
			state_d = ST_DWR;
		end
		if (state_q == ST_DWR) begin
			cmd.decay_wr = 1'b1;
			state_d = stat.sweep_last ? ST_IDLE : ST_DRD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

	`ASSERT_IMP(a_onehot, clk, arst_n, 1'b1, $onehot(state_q), "state not one-hot")
	`ASSERT_NXT(a_read_write, clk, arst_n, state_q == ST_READ, state_q == ST_WRITE,
		"read not followed by write")
	`ASSERT_IMP(a_ready_idle, clk, arst_n, in_ready, state_q == ST_IDLE, "ready outside idle")
endmodule

### rtl/drrip_dp.sv
// datapath: set row memory, victim search, update, selector, decay counter
// depends on drrip_pkg
`timescale 1ns / 1ps
module drrip_dp import drrip_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	output dp_stat_t          stat,
	input  logic              action,
	input  logic [10:0]       set_index,
	input  logic [3:0]        way_index,
	input  logic              hit,
	input  logic [15:0]       valid_mask,
	input  logic [4:0]        chance_bits,
	input  logic [4:0]        period_q,
	output logic              res_valid,
	output logic [3:0]        res_way
);
	// row layout: way w holds {dead[1:0], rv[1:0]} at bits 4w+3:4w
	logic [ROW_W-1:0] mem [SETS];
	logic [ROW_W-1:0] rdata_q;
	logic [SET_W-1:0] set_q, sweep_q;
	logic [3:0] way_q;
	logic act_q, hit_q, bim_q;
	logic [15:0] valid_q;
	logic [SELECTOR_BITS-1:0] sel_q;
	logic [CNT_W-1:0] cnt_q;

	localparam logic [SELECTOR_BITS-1:0] SEL_HALF = SELECTOR_BITS'(1) << (SELECTOR_BITS - 1);
	localparam logic [SELECTOR_BITS-1:0] SEL_MAX = '1;

	assign stat.sweep_last = (sweep_q == SET_W'(SETS - 1));
	assign stat.is_victim = (act_q == ACT_VICTIM);

	// victim search over the read row
	logic [ROW_W-1:0] vrow, urow, drow;
	logic [3:0] vway;
	logic [1:0] top;
	logic found_inv, found_dead;
	logic [3:0] inv_w, dead_w, best_w;
	logic lead_s, lead_b;
	logic [1:0] ins;

	always_comb begin
		found_inv = 1'b0; inv_w = '0;
		found_dead = 1'b0; dead_w = '0;
		top = '0; best_w = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (!valid_q[w]) begin found_inv = 1'b1; inv_w = 4'(w); end
			if (rdata_q[4*w+2 +: 2] == DEAD_MAX) begin found_dead = 1'b1; dead_w = 4'(w); end
		end
		for (int w = 0; w < WAYS; w++)
			if (rdata_q[4*w +: 2] > top) begin top = rdata_q[4*w +: 2]; best_w = 4'(w); end
		vrow = rdata_q;
		if (found_inv) vway = inv_w;
		else if (found_dead) vway = dead_w;
		else begin
			vway = best_w;
			for (int w = 0; w < WAYS; w++)
				vrow[4*w +: 2] = rdata_q[4*w +: 2] + (RV_MAX - top);
		end
	end

	// update of one block, and the decayed row for the sweep
	always_comb begin
		lead_s = set_q < SET_W'(LEADER_SETS / 2);
		lead_b = !lead_s && set_q < SET_W'(LEADER_SETS);
		if (lead_s) ins = 2'd2;
		else if (lead_b) ins = bim_q ? 2'd2 : 2'd3;
		else ins = (sel_q >= SEL_HALF) ? 2'd2 : (bim_q ? 2'd2 : 2'd3);
		urow = rdata_q;
		if (hit_q) urow[4*way_q +: 4] = 4'd0;
		else urow[4*way_q +: 4] = {(rdata_q[4*way_q+2 +: 2] == DEAD_MAX) ? DEAD_MAX :
			2'(rdata_q[4*way_q+2 +: 2] + 2'd1), ins};
		drow = rdata_q;
		for (int w = 0; w < WAYS; w++)
			if (rdata_q[4*w+2 +: 2] != 2'd0) drow[4*w+2 +: 2] = rdata_q[4*w+2 +: 2] - 2'd1;
	end

	// next update count and decay check
	logic [CNT_W-1:0] cnt_n, pmask;
	logic [4:0] p;
	always_comb begin
		cnt_n = cnt_q + CNT_W'(1);
		p = (period_q > 5'd20) ? 5'd20 : period_q;
		pmask = (CNT_W'(1) << p) - CNT_W'(1);
	end

	// the update being written brings the count to a decay point
	assign stat.decay_due = ((cnt_n & pmask) == '0);

	// memory port
	always_ff @(posedge clk) begin
		if (cmd.clr) mem[sweep_q] <= {WAYS{4'b0011}};
		else if (cmd.decay_wr) mem[sweep_q] <= drow;
		else if (cmd.write) mem[set_q] <= (act_q == ACT_VICTIM) ? vrow : urow;
		if (cmd.read) rdata_q <= mem[set_q];
		else if (cmd.decay_rd) rdata_q <= mem[sweep_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action; set_q <= set_index; way_q <= way_index; hit_q <= hit;
			valid_q <= valid_mask; bim_q <= (chance_bits == 5'd0);
		end
		if (cmd.write) res_way <= vway;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= SEL_HALF; cnt_q <= '0; sweep_q <= '0;
			res_valid <= 1'b0;
		end else begin
			if (cmd.clr || cmd.decay_wr) sweep_q <= sweep_q + SET_W'(1);
			res_valid <= cmd.write && act_q == ACT_VICTIM;
			if (cmd.write && act_q == ACT_UPDATE) begin
				cnt_q <= cnt_n;
				if (lead_s) begin
					if (hit_q) begin
						if (sel_q != SEL_MAX) sel_q <= sel_q + SELECTOR_BITS'(1);
					end else if (sel_q != '0) sel_q <= sel_q - SELECTOR_BITS'(1);
				end else if (lead_b) begin
					if (hit_q) begin
						if (sel_q != '0) sel_q <= sel_q - SELECTOR_BITS'(1);
					end else if (sel_q != SEL_MAX) sel_q <= sel_q + SELECTOR_BITS'(1);
				end
			end
		end
	end
endmodule

### rtl/drrip_dead_block_replacement.sv
// channel  | dir | signals
// in       | in  | in_valid in_ready action set_index way_index hit valid_mask chance_bits
// out      | out | out_valid out_ready victim_way
// cfg      | in  | cfg_valid cfg_ready decay_period_log2
// an update goes through capture, row read and row write (the single memory port sets this)
// a victim request goes through the same steps, and its result is then loaded into the
// output register before the next beat is taken
// after reset a clearing pass writes all 2048 set rows, one a cycle, before any beat is taken
// an update that triggers decay adds a sweep that reads and writes back each of the 2048 set rows
// a result sits in an output register; the next beat waits while it is not taken
// depends on drrip_pkg, drrip_ctrl, drrip_dp
`timescale 1ns / 1ps
module drrip_dead_block_replacement import drrip_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [10:0] set_index,
	input  logic [3:0]  way_index,
	input  logic        hit,
	input  logic [15:0] valid_mask,
	input  logic [4:0]  chance_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  victim_way,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  decay_period_log2
);
	dp_cmd_t cmd;
	dp_stat_t stat;
	logic [4:0] period_q;
	logic res_valid;
	logic [3:0] res_way;
	logic hold_q;
	logic [3:0] way_q;

	// config register, written only between requests with no input beat offered
	assign cfg_ready = in_ready && !in_valid;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) period_q <= 5'd12;
		else if (cfg_valid && cfg_ready) period_q <= decay_period_log2;
	end

	// output register holding one result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) hold_q <= 1'b0;
		else if (res_valid) hold_q <= 1'b1;
		else if (out_ready) hold_q <= 1'b0;
	end
	always_ff @(posedge clk) if (res_valid) way_q <= res_way;
	assign out_valid = hold_q;
	assign victim_way = way_q;

	// busy while a result is on its way in or the held beat is not taken this cycle
	drrip_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_busy(res_valid || (hold_q && !out_ready)),
		.stat, .cmd
	);

	drrip_dp u_dp (
		.clk, .arst_n, .cmd, .stat, .action, .set_index, .way_index, .hit,
		.valid_mask, .chance_bits, .period_q, .res_valid, .res_way
	);
endmodule

### test/drrip_dead_block_replacement_tb.sv
// testbench for drrip_dead_block_replacement: directed and random victim and update beats
// checked against an in-bench replacement predictor; depends on drrip_pkg and the rtl
`timescale 1ns / 1ps
module drrip_dead_block_replacement_tb;
	import drrip_pkg::*;

	// one queued beat: either a register write or a request
	typedef struct packed {
		logic        is_cfg;
		logic [4:0]  period;
		logic        act;
		logic [10:0] set_i;
		logic [3:0]  way_i;
		logic        hit_i;
		logic [15:0] vmask;
		logic [4:0]  chance;
	} beat_t;

	localparam int DRAIN_CYCLES = 4400; // capture/read/write plus a full decay sweep

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        action;
	logic [10:0] set_index;
	logic [3:0]  way_index;
	logic        hit;
	logic [15:0] valid_mask;
	logic [4:0]  chance_bits;
	logic        out_valid;
	logic        out_ready;
	logic [3:0]  victim_way;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [4:0]  decay_period_log2;

	drrip_dead_block_replacement u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .set_index(set_index), .way_index(way_index), .hit(hit),
		.valid_mask(valid_mask), .chance_bits(chance_bits),
		.out_valid(out_valid), .out_ready(out_ready), .victim_way(victim_way),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.decay_period_log2(decay_period_log2)
	);

	// predicted cache policy state
	logic [1:0]  rrv [SETS][WAYS];
	logic [1:0]  dead [SETS][WAYS];
	logic [SELECTOR_BITS-1:0] psel;
	logic [CNT_W-1:0] upd_count;
	logic [4:0]  period_reg;

	beat_t       pending_beats[$];
	logic [3:0]  victims_due[$];
	int          err_count;
	bit          idle_on;
	int          send_gap;
	int          recv_stall;
	beat_t       cur;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// bimodal insertion: mostly distant (3), long (2) only when the random bits are all zero
	function automatic logic [1:0] bimodal_ins(logic [4:0] ch);
		return (ch == 5'd0) ? 2'd2 : 2'd3;
	endfunction

	function automatic logic [3:0] choose_victim(int s, logic [15:0] vm);
		logic [1:0] top;
		int best;
		top = 2'd0;
		best = 0;
		// invalid way first
		for (int w = 0; w < WAYS; w++)
			if (!vm[w]) return w[3:0];
		// then a block predicted dead
		for (int w = 0; w < WAYS; w++)
			if (dead[s][w] == DEAD_MAX) return w[3:0];
		// lowest way with the largest re-reference value, aging the set up to distant
		for (int w = 0; w < WAYS; w++)
			if (rrv[s][w] > top) begin
				top = rrv[s][w];
				best = w;
			end
		if (top < RV_MAX)
			for (int w = 0; w < WAYS; w++) rrv[s][w] = rrv[s][w] + (RV_MAX - top);
		return best[3:0];
	endfunction

	function automatic void apply_update(int s, int w, logic h, logic [4:0] ch);
		bit lead_s;
		bit lead_b;
		int p;
		lead_s = s < LEADER_SETS / 2;
		lead_b = !lead_s && s < LEADER_SETS;
		if (h) begin
			dead[s][w] = 2'd0;
			rrv[s][w] = 2'd0;
		end else begin
			if (dead[s][w] < DEAD_MAX) dead[s][w] = dead[s][w] + 2'd1;
			if (lead_s) rrv[s][w] = 2'd2;
			else if (lead_b) rrv[s][w] = bimodal_ins(ch);
			else rrv[s][w] = psel[SELECTOR_BITS-1] ? 2'd2 : bimodal_ins(ch);
		end
		// static leaders vote for static on hits, bimodal leaders the reverse
		if ((lead_s && h) || (lead_b && !h)) begin
			if (psel != '1) psel = psel + SELECTOR_BITS'(1);
		end else if (lead_s || lead_b) begin
			if (psel != '0) psel = psel - SELECTOR_BITS'(1);
		end
		upd_count = upd_count + CNT_W'(1);
		p = (period_reg > 5'd20) ? 20 : int'(period_reg);
		if ((upd_count & ((CNT_W'(1) << p) - CNT_W'(1))) == '0)
			for (int i = 0; i < SETS; i++)
				for (int j = 0; j < WAYS; j++)
					if (dead[i][j] != 2'd0) dead[i][j] = dead[i][j] - 2'd1;
	endfunction

	function automatic beat_t mk_req(logic a, int s, int w, logic h, logic [15:0] vm,
			logic [4:0] ch);
		beat_t b;
		b = '0;
		b.act = a;
		b.set_i = s[10:0];
		b.way_i = w[3:0];
		b.hit_i = h;
		b.vmask = vm;
		b.chance = ch;
		return b;
	endfunction

	function automatic beat_t mk_cfg(logic [4:0] v);
		beat_t b;
		b = '0;
		b.is_cfg = 1'b1;
		b.period = v;
		return b;
	endfunction

	// random beat, concentrated on a few leader and follower sets so that
	// sets age, blocks go dead and the selector moves
	function automatic beat_t rand_req();
		int pool[10] = '{0, 1, 31, 32, 33, 63, 64, 65, 700, 2047};
		int s;
		logic [15:0] vm;
		logic [4:0] ch;
		s = ($urandom_range(0, 9) < 8) ? pool[$urandom_range(0, 9)] : $urandom_range(0, 2047);
		case ($urandom_range(0, 4))
			0: vm = 16'($urandom());
			1: vm = ~(16'd1 << $urandom_range(0, 15));
			default: vm = 16'hFFFF;
		endcase
		ch = ($urandom_range(0, 4) == 0) ? 5'd0 : 5'($urandom_range(0, 31));
		return mk_req($urandom_range(0, 1) ? ACT_UPDATE : ACT_VICTIM, s,
			$urandom_range(0, 15), $urandom_range(0, 9) < 4, vm, ch);
	endfunction

	// request and config driver, one nonblocking write per signal per edge
	always @(posedge clk or negedge arst_n) begin
		logic nxt_in;
		logic nxt_cfg;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cfg_valid <= 1'b0;
			action <= ACT_VICTIM;
			set_index <= '0;
			way_index <= '0;
			hit <= 1'b0;
			valid_mask <= '0;
			chance_bits <= '0;
			decay_period_log2 <= '0;
			send_gap = 0;
		end else begin
			nxt_in = in_valid;
			nxt_cfg = cfg_valid;
			if (in_valid && in_ready) begin
				nxt_in = 1'b0;
				if (cur.act == ACT_VICTIM)
					victims_due.push_back(choose_victim(cur.set_i, cur.vmask));
				else
					apply_update(cur.set_i, cur.way_i, cur.hit_i, cur.chance);
			end
			if (cfg_valid && cfg_ready) begin
				nxt_cfg = 1'b0;
				period_reg = cur.period;
			end
			if (!nxt_in && !nxt_cfg) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_beats.size() > 0) begin
					cur = pending_beats.pop_front();
					if (cur.is_cfg) begin
						nxt_cfg = 1'b1;
						decay_period_log2 <= cur.period;
					end else begin
						nxt_in = 1'b1;
						action <= cur.act;
						set_index <= cur.set_i;
						way_index <= cur.way_i;
						hit <= cur.hit_i;
						valid_mask <= cur.vmask;
						chance_bits <= cur.chance;
					end
					if (idle_on && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 10);
				end
			end
			in_valid <= nxt_in;
			cfg_valid <= nxt_cfg;
		end
	end

	// result monitor with random receive stalls
	always @(posedge clk or negedge arst_n) begin
		logic [3:0] want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_stall = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (victims_due.size() == 0) begin
					$error("unexpected result beat: victim_way %0d", victim_way);
					err_count++;
				end else begin
					want = victims_due.pop_front();
					if (victim_way !== want) begin
						$error("victim_way mismatch: expected %0d, actual %0d", want, victim_way);
						err_count++;
					end
				end
			end
			if (recv_stall > 0) begin
				recv_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (idle_on && $urandom_range(0, 5) == 0) recv_stall = $urandom_range(1, 10);
			end
		end
	end

	// wait until the block has drained, including a possible decay sweep
	task automatic drain();
		do @(posedge clk);
		while (pending_beats.size() != 0 || in_valid || cfg_valid || victims_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(int n);
		for (int i = 0; i < n; i++) pending_beats.push_back(rand_req());
		drain();
	endtask

	initial begin
		err_count = 0;
		idle_on = 1'b1;
		for (int i = 0; i < SETS; i++)
			for (int j = 0; j < WAYS; j++) begin
				rrv[i][j] = RV_MAX;
				dead[i][j] = 2'd0;
			end
		psel = SELECTOR_BITS'(1) << (SELECTOR_BITS - 1);
		upd_count = '0;
		period_reg = 5'd12;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: invalid ways, dead block, aging, leaders, insertion values
		pending_beats.push_back(mk_req(ACT_VICTIM, 0, 0, 0, 16'h0000, 0));
		pending_beats.push_back(mk_req(ACT_VICTIM, 2047, 0, 0, 16'hFFFE, 31));
		pending_beats.push_back(mk_req(ACT_VICTIM, 64, 0, 0, 16'hFFFF, 0));
		pending_beats.push_back(mk_req(ACT_VICTIM, 5, 0, 0, 16'h7FFF, 0));
		pending_beats.push_back(mk_req(ACT_UPDATE, 0, 15, 1, 16'hFFFF, 31));
		pending_beats.push_back(mk_req(ACT_UPDATE, 32, 0, 0, 16'hFFFF, 0));
		pending_beats.push_back(mk_req(ACT_UPDATE, 32, 1, 0, 16'hFFFF, 31));
		pending_beats.push_back(mk_req(ACT_UPDATE, 100, 7, 0, 16'h0000, 0));
		pending_beats.push_back(mk_req(ACT_UPDATE, 100, 7, 0, 16'h0000, 1));
		pending_beats.push_back(mk_req(ACT_UPDATE, 100, 7, 0, 16'h0000, 5));
		pending_beats.push_back(mk_req(ACT_VICTIM, 100, 0, 0, 16'hFFFF, 0));
		pending_beats.push_back(mk_req(ACT_UPDATE, 31, 0, 1, 16'hFFFF, 0));
		pending_beats.push_back(mk_req(ACT_UPDATE, 63, 2, 1, 16'hFFFF, 0));
		pending_beats.push_back(mk_req(ACT_UPDATE, 63, 3, 0, 16'hFFFF, 16));
		pending_beats.push_back(mk_req(ACT_VICTIM, 0, 0, 0, 16'hFFFF, 0));
		pending_beats.push_back(mk_req(ACT_UPDATE, 1, 0, 1, 16'hFFFF, 0));
		pending_beats.push_back(mk_req(ACT_UPDATE, 1, 1, 0, 16'hFFFF, 0));
		pending_beats.push_back(mk_req(ACT_VICTIM, 1, 0, 0, 16'hFFFF, 0));
		pending_beats.push_back(mk_req(ACT_VICTIM, 1, 0, 0, 16'hFFFF, 0));
		drain();

		// period zero decays on every update, so keep this phase short
		pending_beats.push_back(mk_cfg(5'd0));
		run_random(12);
		pending_beats.push_back(mk_cfg(5'd1));
		run_random(20);
		pending_beats.push_back(mk_cfg(5'd31));
		run_random(200);
		pending_beats.push_back(mk_cfg(5'd3));
		run_random(200);
		pending_beats.push_back(mk_cfg(5'd20));
		run_random(200);
		// last stretch runs without any idling
		pending_beats.push_back(mk_cfg(5'd5));
		idle_on = 1'b0;
		run_random(200);

		if (err_count == 0 && victims_due.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

### files.f
+incdir+rtl
rtl/drrip_pkg.sv
rtl/drrip_ctrl.sv
rtl/drrip_dp.sv
rtl/drrip_dead_block_replacement.sv
test/drrip_dead_block_replacement_tb.sv
